[src/skt_pkg.sv]
// Package for the sorted key table: widths, codes and result type.
package skt_pkg;
    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int POS_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_FIND     = 3'd2;
    localparam logic [2:0] OP_FIND_INF = 3'd3;
    localparam logic [2:0] OP_FIND_ALL = 3'd4;
    localparam logic [2:0] OP_READ_AT  = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BEYOND    = 2'd3;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [KEY_BITS-1:0]    result_key;
        logic [HANDLE_BITS-1:0] result_handle;
        logic [POS_BITS-1:0]    result_position;
        logic                   last_of_run;
        logic [CNT_BITS-1:0]    entry_count_out;
    } result_t;
endpackage

[src/skt_out_buf.sv]
// Two-entry skid buffer holding result items for the master side.
module skt_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  skt_pkg::result_t push_data,
    output logic             space,
    output logic             empty,
    output logic             out_valid,
    input  logic             out_ready,
    output skt_pkg::result_t out_data
);
    skt_pkg::result_t buf_reg [2];
    logic             rd_reg;
    logic             wr_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_reg];
    assign space     = (cnt_reg != 2'd2);
    assign empty     = (cnt_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[src/sorted_key_table.sv]
// Sorted key table: up to 64 (signed key, handle) entries in ascending key order,
// held in one synchronous single-port memory with a registered read. Find,
// find_inf and find_all run a binary search, then read the hit (find_all reading
// on entry by entry, waiting while the output buffer is full). Insert searches,
// then shifts the entries above the new position one place, each entry read and
// then written back; delete scans by handle and then shifts. One item is worked
// on at a time; the next item is taken once its results are in the output buffer
// and drained.
module sorted_key_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [34:3] search_key, [50:35] entry_handle, [56:51] position
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] found, [34:3] result_key, [50:35] result_handle,
    // [56:51] result_position, [63:57] entry_count_out
    output logic [63:0] m_tdata,
    output logic        m_tlast
);
    localparam int PB = skt_pkg::POS_BITS;
    localparam int CB = skt_pkg::CNT_BITS;
    localparam int KB = skt_pkg::KEY_BITS;
    localparam int HB = skt_pkg::HANDLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_BS_RD, S_BS_CMP, S_HIT_RD, S_HIT_OUT, S_DS_RD, S_DS_CMP,
        S_SH_RD, S_SH_WR, S_INS_WR, S_EMIT, S_INF_RD
    } state_t;

    logic [KB+HB-1:0] mem [skt_pkg::DEPTH];
    logic [KB+HB-1:0] rdata_reg;

    state_t            state_reg;
    logic [2:0]        op_reg;
    logic [KB-1:0]     key_reg;
    logic [HB-1:0]     hnd_reg;
    logic [CB-1:0]     lo_reg, hi_reg, cnt_reg, ptr_reg;
    skt_pkg::result_t  res_reg;
    logic              push_reg;

    logic              mem_we;
    logic [PB-1:0]     mem_addr;
    logic [KB+HB-1:0]  mem_wdata;
    logic              space, empty;
    skt_pkg::result_t  ob_data;
    skt_pkg::result_t  res_init;
    logic [CB-1:0]     mid;
    logic [KB-1:0]     rkey;
    logic [HB-1:0]     rhnd;
    logic              rless, kless, keq;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rkey  = rdata_reg[KB+HB-1:HB];
    assign rhnd  = rdata_reg[HB-1:0];
    assign rless = $signed(rkey) < $signed(key_reg);
    assign kless = $signed(key_reg) < $signed(rkey);
    assign keq   = rkey == key_reg;

    assign s_tready = (state_reg == S_IDLE) && empty && !push_reg;

    always_comb
    begin
        res_init                 = '0;
        res_init.last_of_run     = 1'b1;
        res_init.entry_count_out = cnt_reg;
        case (s_tdata[2:0])
            skt_pkg::OP_INSERT:
            begin
                if (cnt_reg >= CB'(skt_pkg::DEPTH))
                begin
                    res_init.status = skt_pkg::ST_FULL;
                end
            end
            skt_pkg::OP_READ_AT:
            begin
                if (CB'(s_tdata[56:51]) >= cnt_reg)
                begin
                    res_init.status = skt_pkg::ST_BEYOND;
                end
            end
            skt_pkg::OP_CLEAR: res_init.entry_count_out = '0;
            default:           res_init.status = skt_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = mid[PB-1:0];
        mem_wdata = rdata_reg;
        case (state_reg)
            S_HIT_RD, S_INF_RD: mem_addr = lo_reg[PB-1:0];
            S_DS_RD:  mem_addr = ptr_reg[PB-1:0];
            S_SH_RD:
            begin
                if (op_reg == skt_pkg::OP_INSERT)
                begin
                    mem_addr = PB'(ptr_reg - CB'(1));
                end
                else
                begin
                    mem_addr = PB'(ptr_reg + CB'(1));
                end
            end
            S_SH_WR:
            begin
                mem_we   = 1'b1;
                mem_addr = ptr_reg[PB-1:0];
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = lo_reg[PB-1:0];
                mem_wdata = {key_reg, hnd_reg};
            end
            default: mem_addr = mid[PB-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            push_reg  <= 1'b0;
            op_reg    <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            push_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg  <= s_tdata[2:0];
                        key_reg <= s_tdata[34:3];
                        hnd_reg <= s_tdata[50:35];
                        hi_reg  <= cnt_reg;
                        ptr_reg <= '0;
                        res_reg <= res_init;
                        case (s_tdata[2:0])
                            skt_pkg::OP_INSERT:
                            begin
                                lo_reg <= '0;
                                if (cnt_reg >= CB'(skt_pkg::DEPTH))
                                begin
                                    push_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_BS_RD;
                                end
                            end
                            skt_pkg::OP_DELETE:
                            begin
                                lo_reg    <= '0;
                                state_reg <= S_DS_RD;
                            end
                            skt_pkg::OP_FIND, skt_pkg::OP_FIND_INF,
                            skt_pkg::OP_FIND_ALL:
                            begin
                                lo_reg    <= '0;
                                state_reg <= S_BS_RD;
                            end
                            skt_pkg::OP_READ_AT:
                            begin
                                lo_reg <= CB'(s_tdata[56:51]);
                                if (CB'(s_tdata[56:51]) < cnt_reg)
                                begin
                                    state_reg <= S_HIT_RD;
                                end
                                else
                                begin
                                    push_reg <= 1'b1;
                                end
                            end
                            skt_pkg::OP_CLEAR:
                            begin
                                lo_reg   <= '0;
                                cnt_reg  <= '0;
                                push_reg <= 1'b1;
                            end
                            default:
                            begin
                                lo_reg   <= '0;
                                push_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_BS_RD:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= S_BS_CMP;
                    end
                    else if (op_reg == skt_pkg::OP_INSERT)
                    begin
                        ptr_reg   <= cnt_reg;
                        state_reg <= S_SH_RD;
                    end
                    else if (lo_reg >= cnt_reg)
                    begin
                        res_reg.status <= skt_pkg::ST_NOT_FOUND;
                        push_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_HIT_RD;
                    end
                end
                S_BS_CMP:
                begin
                    if ((op_reg == skt_pkg::OP_INSERT) ? !kless : rless)
                    begin
                        lo_reg <= mid + CB'(1);
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_BS_RD;
                end
                S_HIT_RD:
                begin
                    // a later find_all read (ptr != 0) pushes the held result from S_HIT_OUT, so it needs room first
                    if (op_reg != skt_pkg::OP_FIND_ALL || ptr_reg == '0 || space)
                    begin
                        state_reg <= S_HIT_OUT;
                    end
                end
                S_HIT_OUT:
                begin
                    case (op_reg)
                        skt_pkg::OP_READ_AT:
                        begin
                            res_reg.found           <= 1'b1;
                            res_reg.result_key      <= rkey;
                            res_reg.result_handle   <= rhnd;
                            res_reg.result_position <= lo_reg[PB-1:0];
                            push_reg                <= 1'b1;
                            state_reg               <= S_IDLE;
                        end
                        skt_pkg::OP_FIND_INF:
                        begin
                            if (lo_reg != '0 && !keq)
                            begin
                                lo_reg    <= lo_reg - CB'(1);
                                state_reg <= S_INF_RD;
                            end
                            else
                            begin
                                res_reg.found           <= 1'b1;
                                res_reg.result_key      <= rkey;
                                res_reg.result_handle   <= rhnd;
                                res_reg.result_position <= lo_reg[PB-1:0];
                                push_reg                <= 1'b1;
                                state_reg               <= S_IDLE;
                            end
                        end
                        skt_pkg::OP_FIND_ALL:
                        begin
                            if (keq)
                            begin
                                res_reg.found           <= 1'b1;
                                res_reg.result_key      <= rkey;
                                res_reg.result_handle   <= rhnd;
                                res_reg.result_position <= lo_reg[PB-1:0];
                                state_reg               <= S_EMIT;
                            end
                            else if (ptr_reg == '0)
                            begin
                                res_reg.status <= skt_pkg::ST_NOT_FOUND;
                                push_reg       <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (keq)
                            begin
                                res_reg.found           <= 1'b1;
                                res_reg.result_key      <= rkey;
                                res_reg.result_handle   <= rhnd;
                                res_reg.result_position <= lo_reg[PB-1:0];
                            end
                            else
                            begin
                                res_reg.status <= skt_pkg::ST_NOT_FOUND;
                            end
                            push_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_INF_RD:
                begin
                    op_reg    <= skt_pkg::OP_READ_AT;
                    state_reg <= S_HIT_OUT;
                end
                S_EMIT:
                begin
                    // peek at next entry to decide last_of_run
                    if (lo_reg + CB'(1) >= cnt_reg)
                    begin
                        if (space)
                        begin
                            push_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        lo_reg    <= lo_reg + CB'(1);
                        ptr_reg   <= ptr_reg + CB'(1);
                        state_reg <= S_BS_RD;
                        hi_reg    <= lo_reg + CB'(1);
                    end
                end
                S_DS_RD:
                begin
                    if (ptr_reg >= cnt_reg)
                    begin
                        res_reg.status <= skt_pkg::ST_NOT_FOUND;
                        push_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DS_CMP;
                    end
                end
                S_DS_CMP:
                begin
                    if (rhnd == hnd_reg)
                    begin
                        res_reg.found           <= 1'b1;
                        res_reg.result_key      <= rkey;
                        res_reg.result_handle   <= rhnd;
                        res_reg.result_position <= ptr_reg[PB-1:0];
                        res_reg.entry_count_out <= cnt_reg - CB'(1);
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + CB'(1);
                        state_reg <= S_DS_RD;
                    end
                end
                S_SH_RD:
                begin
                    if (op_reg == skt_pkg::OP_INSERT)
                    begin
                        state_reg <= (ptr_reg > lo_reg) ? S_SH_WR : S_INS_WR;
                    end
                    else if (ptr_reg + CB'(1) < cnt_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - CB'(1);
                        push_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SH_WR:
                begin
                    ptr_reg   <= (op_reg == skt_pkg::OP_INSERT) ?
                                 ptr_reg - CB'(1) : ptr_reg + CB'(1);
                    state_reg <= S_SH_RD;
                end
                S_INS_WR:
                begin
                    cnt_reg <= cnt_reg + CB'(1);
                    res_reg.found           <= 1'b1;
                    res_reg.result_key      <= key_reg;
                    res_reg.result_handle   <= hnd_reg;
                    res_reg.result_position <= lo_reg[PB-1:0];
                    res_reg.entry_count_out <= cnt_reg + CB'(1);
                    push_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // find_all: the hit in S_HIT_OUT loads res_reg; S_EMIT then reads the next
    // entry through S_BS_RD (lo == hi, lo < cnt), S_HIT_RD and S_HIT_OUT. A non-equal next
    // entry ends the run; the held result goes out with last set.
    logic             fa_push;
    skt_pkg::result_t fa_data;
    assign fa_push = (state_reg == S_HIT_OUT) && (op_reg == skt_pkg::OP_FIND_ALL)
                     && (ptr_reg != '0);
    always_comb
    begin
        fa_data             = res_reg;
        fa_data.last_of_run = !keq;
    end

    skt_pkg::result_t push_data;
    always_comb
    begin
        push_data = fa_push ? fa_data : res_reg;
    end

    skt_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_reg || fa_push),
        .push_data (push_data),
        .space     (space),
        .empty     (empty),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (ob_data)
    );

    assign m_tdata = {ob_data.entry_count_out, ob_data.result_position,
                      ob_data.result_handle, ob_data.result_key,
                      ob_data.found, ob_data.status};
    assign m_tlast = ob_data.last_of_run;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CB'(skt_pkg::DEPTH))
        else $error("entry count beyond depth");
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("accept outside idle");
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ob_data.found |-> ob_data.status == skt_pkg::ST_OK)
        else $error("entry returned with bad status");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_reg || fa_push) |-> space)
        else $error("result pushed into full buffer");
endmodule
